### hw/rtl/spi_pkg.sv
package spi_pkg;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [15:0] start_qz;
        logic signed [15:0] start_qw;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [15:0] end_qz;
        logic signed [15:0] end_qw;
    } seg_in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [15:0] point_qz;
        logic signed [15:0] point_qw;
        logic               is_last;
        logic               truncated;
    } pt_out_t;

    localparam logic [30:0] STEP_RESET = 31'd16384;

    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_SQRT  = 4'd2,
        OP_DIVN  = 4'd3,
        OP_DIVR  = 4'd4,
        OP_MULX  = 4'd5,
        OP_MULY  = 4'd6,
        OP_LASTX = 4'd7,
        OP_LASTY = 4'd8,
        OP_EMIT  = 4'd9
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   start;
        logic   emit_end;
    } dp_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       zero_len;
        logic [6:0] n_low;
        logic       big_n;
        logic       differ;
    } dp_sts_t;

endpackage

### hw/rtl/spi_datapath.sv
module spi_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  spi_pkg::seg_in_t   seg,
    input  logic [30:0]        step_len,
    input  spi_pkg::dp_cmd_t   cmd,
    input  logic               last_flag,
    input  logic               trunc_flag,
    output spi_pkg::dp_sts_t   sts,
    output spi_pkg::pt_out_t   pt
);
    import spi_pkg::*;

    seg_in_t     seg_reg;
    logic [32:0] ax_reg, ay_reg;
    logic        sgx_reg, sgy_reg, sh_reg;
    logic [63:0] rad_reg, bit_reg, res_reg;
    logic [32:0] dist_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] n_reg;
    logic [32:0] r_reg;
    logic signed [33:0] incx_reg, incy_reg;
    logic signed [33:0] px_reg, py_reg;
    logic signed [41:0] prod_reg;
    logic        differ_reg;

    logic [32:0] dx, dy;
    logic signed [33:0] dxs, dys;
    logic [30:0] hx, hy;
    logic [32:0] mul_a;
    logic [65:0] mprod;
    logic [63:0] trial;
    logic [64:0] rsh;

    assign dxs = 34'(signed'(seg.end_x)) - 34'(signed'(seg.start_x));
    assign dys = 34'(signed'(seg.end_y)) - 34'(signed'(seg.start_y));
    assign dx = dxs[33] ? 33'(-dxs) : dxs[32:0];
    assign dy = dys[33] ? 33'(-dys) : dys[32:0];
    assign hx = 31'(ax_reg >> sh_reg);
    assign hy = 31'(ay_reg >> sh_reg);
    assign mul_a = (cmd.op == OP_MULY) ? ay_reg : ax_reg;
    assign mprod = 66'(mul_a) * 66'(r_reg);
    assign trial = res_reg + bit_reg;
    assign rsh = {rem_reg, quo_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            unique case (cmd.op) inside
                OP_LOAD: begin
                    seg_reg <= seg;
                    ax_reg <= dx;
                    ay_reg <= dy;
                    sgx_reg <= dxs[33];
                    sgy_reg <= dys[33];
                    sh_reg <= dx[32] | dy[32] | (dx[31] | dy[31]);
                    busy_reg <= 1'b0;
                end
                OP_SQRT: begin
                    if (cmd.start) begin
                        rad_reg <= 64'(hx) * 64'(hx) + 64'(hy) * 64'(hy);
                        bit_reg <= 64'd1 << 62;
                        res_reg <= '0;
                        busy_reg <= 1'b1;
                    end else if (bit_reg == 0) begin
                        dist_reg <= (res_reg == 0) ? 33'd1 : 33'(res_reg << sh_reg);
                        busy_reg <= 1'b0;
                    end else begin
                        if (rad_reg >= trial) begin
                            rad_reg <= rad_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                OP_DIVN, OP_DIVR: begin
                    if (cmd.start) begin
                        quo_reg <= (cmd.op == OP_DIVN) ? 64'(dist_reg)
                                 : 64'({33'd0, (step_len == 0) ? 31'd1 : step_len} << 30);
                        dvs_reg <= (cmd.op == OP_DIVN)
                                 ? 64'((step_len == 0) ? 31'd1 : step_len) : 64'(dist_reg);
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        busy_reg <= 1'b1;
                    end else if (cnt_reg == 7'd64) begin
                        if (cmd.op == OP_DIVN) n_reg <= quo_reg;
                        else r_reg <= quo_reg[32:0];
                        busy_reg <= 1'b0;
                    end else begin
                        if (rsh >= {1'b0, dvs_reg}) begin
                            rem_reg <= 64'(rsh - {1'b0, dvs_reg});
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end else begin
                            rem_reg <= rsh[63:0];
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                OP_MULX: begin
                    if (n_reg == 0) incx_reg <= '0;
                    else incx_reg <= sgx_reg ? -34'(mprod >> 30) : 34'(mprod >> 30);
                end
                OP_MULY: begin
                    if (n_reg == 0) incy_reg <= '0;
                    else incy_reg <= sgy_reg ? -34'(mprod >> 30) : 34'(mprod >> 30);
                end
                OP_LASTX: begin
                    prod_reg <= 42'(signed'(incx_reg)) * 42'(signed'({1'b0, n_reg[6:0]}));
                    differ_reg <= 1'b0;
                end
                OP_LASTY: begin
                    differ_reg <= differ_reg
                        | (42'(signed'(seg_reg.start_x)) + prod_reg != 42'(signed'(seg_reg.end_x)))
                        | (42'(signed'(seg_reg.start_y))
                           + 42'(signed'(incy_reg)) * 42'(signed'({1'b0, n_reg[6:0]}))
                           != 42'(signed'(seg_reg.end_y)));
                    px_reg <= 34'(signed'(seg_reg.start_x));
                    py_reg <= 34'(signed'(seg_reg.start_y));
                end
                OP_EMIT: begin
                    px_reg <= px_reg + incx_reg;
                    py_reg <= py_reg + incy_reg;
                end
                default: begin
                end
            endcase
        end
    end

    assign sts.busy = busy_reg;
    assign sts.zero_len = (ax_reg == 0) && (ay_reg == 0);
    assign sts.n_low = n_reg[6:0];
    assign sts.big_n = (n_reg >= 64'(MAX_POINTS));
    assign sts.differ = differ_reg;

    always_comb begin
        if (cmd.emit_end) begin
            pt.point_x = seg_reg.end_x;
            pt.point_y = seg_reg.end_y;
            pt.point_qz = seg_reg.end_qz;
            pt.point_qw = seg_reg.end_qw;
        end else begin
            pt.point_x = px_reg[31:0];
            pt.point_y = py_reg[31:0];
            pt.point_qz = seg_reg.start_qz;
            pt.point_qw = seg_reg.start_qw;
        end
        pt.is_last = last_flag;
        pt.truncated = trunc_flag;
    end
endmodule

### hw/rtl/spi_ctrl.sv
module spi_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  spi_pkg::dp_sts_t  sts,
    output spi_pkg::dp_cmd_t  cmd,
    output logic              last_flag,
    output logic              trunc_flag
);
    import spi_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001, ST_CHK = 11'b00000000010, ST_SQRT = 11'b00000000100,
        ST_DIVN = 11'b00000001000, ST_DIVR = 11'b00000010000, ST_MULX = 11'b00000100000,
        ST_MULY = 11'b00001000000, ST_LSTX = 11'b00010000000, ST_LSTY = 11'b00100000000,
        ST_PTS  = 11'b01000000000, ST_END  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic started_reg, started_next;
    logic [6:0] k_reg, k_next, nst_reg, nst_next;
    logic tr_reg, tr_next;
    logic xfer;

    assign xfer = m_valid && m_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = ((state_reg == ST_PTS) && started_reg) || (state_reg == ST_END);
    assign trunc_flag = tr_reg;
    assign last_flag = (state_reg == ST_END) || (k_reg == nst_reg && !sts.differ && !tr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            started_reg <= 1'b0;
            k_reg <= '0;
            nst_reg <= '0;
            tr_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            started_reg <= started_next;
            k_reg <= k_next;
            nst_reg <= nst_next;
            tr_reg <= tr_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        started_next = 1'b0;
        k_next = k_reg;
        nst_next = nst_reg;
        tr_next = tr_reg;
        cmd.op = OP_NONE;
        cmd.start = 1'b0;
        cmd.emit_end = (state_reg == ST_END);
        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                tr_next = 1'b0;
                state_next = sts.zero_len ? ST_END : ST_SQRT;
            end
            ST_SQRT, ST_DIVN, ST_DIVR: begin
                cmd.op = (state_reg == ST_SQRT) ? OP_SQRT
                       : (state_reg == ST_DIVN) ? OP_DIVN : OP_DIVR;
                cmd.start = !started_reg;
                started_next = 1'b1;
                if (started_reg && !sts.busy && !cmd.start) begin
                    started_next = 1'b0;
                    state_next = (state_reg == ST_SQRT) ? ST_DIVN
                               : (state_reg == ST_DIVN) ? ST_DIVR : ST_MULX;
                end
            end
            ST_MULX: begin
                cmd.op = OP_MULX;
                cmd.start = 1'b1;
                state_next = ST_MULY;
            end
            ST_MULY: begin
                cmd.op = OP_MULY;
                cmd.start = 1'b1;
                state_next = ST_LSTX;
            end
            ST_LSTX: begin
                cmd.op = OP_LASTX;
                state_next = ST_LSTY;
            end
            ST_LSTY: begin
                cmd.op = OP_LASTY;
                state_next = ST_PTS;
                k_next = '0;
                state_next = ST_PTS;
            end
            ST_PTS: begin
                if (k_reg == 7'd0 && !started_reg) begin
                    started_next = 1'b1;
                    if (sts.big_n || (!sts.big_n && (32'(sts.n_low) + 32'd1
                        + 32'(sts.differ)) > 32'(MAX_POINTS))) begin
                        tr_next = 1'b1;
                        nst_next = 7'(MAX_POINTS - 2);
                    end else begin
                        nst_next = sts.n_low;
                    end
                end else begin
                    started_next = 1'b1;
                end
                if (xfer) begin
                    cmd.op = OP_EMIT;
                    k_next = k_reg + 7'd1;
                    if (k_reg == nst_reg) begin
                        started_next = 1'b0;
                        state_next = (sts.differ || tr_reg) ? ST_END : ST_IDLE;
                    end
                end
            end
            ST_END: begin
                if (xfer) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

### hw/rtl/segment_point_interpolator.sv
// Channel  | ports           | payload
// input    | s_valid/s_ready | seg_in_t segment
// result   | m_valid/m_ready | pt_out_t point
// config   | cfg_we/cfg_data | step_length, 31 bits
// After its input transfer, a segment passes the length check, the square root, the two
// 64-step divisions, the increments, the end test and the point count before its first
// point is offered. A zero-length segment offers its one point right after the length
// check, and points follow one per cycle while m_ready is high.
// Reset is synchronous and active low; step_length resets to 0.25.
// A stalled result holds until its transfer, and no segment is taken before the last point.
module segment_point_interpolator #(
    parameter int MAX_POINTS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  spi_pkg::seg_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output spi_pkg::pt_out_t m_data,
    input  logic             cfg_we,
    input  logic [30:0]      cfg_data
);
    import spi_pkg::*;

    logic [30:0] step_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic last_flag, trunc_flag;

    always_ff @(posedge aclk) begin
        if (!aresetn) step_reg <= STEP_RESET;
        else if (cfg_we) step_reg <= cfg_data;
    end

    spi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .sts, .cmd, .last_flag, .trunc_flag
    );

    spi_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk, .aresetn, .seg(s_data), .step_len(step_reg), .cmd,
        .last_flag, .trunc_flag, .sts, .pt(m_data)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data)) else $error("result changed");
`endif
endmodule
